FILE: hw/rtl/fpst_pkg.sv
// Shared types, codes and constants for the prefix-sum table.
package fpst_pkg;

    // Fixed field widths of one transaction.
    localparam int VALUE_WIDTH   = 32;
    localparam int IDX_W         = 11;
    localparam int DEPTH_DEFAULT = 1024;

    localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

    // Action codes carried in the action field.
    localparam logic [2:0] ACT_ADD   = 3'd0;
    localparam logic [2:0] ACT_SET   = 3'd1;
    localparam logic [2:0] ACT_SUM   = 3'd2;
    localparam logic [2:0] ACT_LOWER = 3'd3;
    localparam logic [2:0] ACT_UPPER = 3'd4;
    localparam logic [2:0] ACT_CLEAR = 3'd5;

    typedef struct packed {
        logic [2:0]             action;
        logic [IDX_W-1:0]       index_lo;
        logic [IDX_W-1:0]       index_hi;
        logic [VALUE_WIDTH-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] sum_value;
        logic [IDX_W-1:0]       found_index;
        logic                   status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DISPATCH,
        S_W1_RD,
        S_W1_ACC,
        S_W2_RD,
        S_W2_ACC,
        S_URD,
        S_UWR,
        S_SRD,
        S_SCMP,
        S_CLR,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic walk1_init;
        logic walk2_init;
        logic walk_rd;
        logic walk_acc;
        logic upd_init;
        logic upd_rd;
        logic upd_wr;
        logic srch_init;
        logic srch_rd;
        logic srch_cmp;
        logic srch_skip;
        logic clr_init;
        logic clr_wr;
        logic done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] action;
        logic       err;
        logic       k_zero;
        logic       upd_end;
        logic       w_zero;
        logic       in_range;
        logic       clr_last;
    } t_stat;

endpackage

FILE: hw/rtl/fpst_datapath.sv
// Datapath of the prefix-sum table: cell memory, walk registers and result register.
module fpst_datapath import fpst_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_wdata,
    input  t_in_item         i_item,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic             o_done,
    output t_out_item        o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;

    logic [IDX_W-1:0]       r_size;
    t_in_item               r_item;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic                   r_sub;
    logic [CW-1:0]          r_k;
    logic [CW-1:0]          r_ui;
    logic [VALUE_WIDTH-1:0] r_amt;
    logic [CW-1:0]          r_pos;
    logic [CW-1:0]          r_w;
    logic [VALUE_WIDTH-1:0] r_target;
    logic [AW-1:0]          r_ci;
    logic                   r_done;
    t_out_item              r_result;

    logic [CW-1:0]          size_x;
    logic [CW-1:0]          live_n;
    logic [CW-1:0]          lo_x;
    logic [CW-1:0]          hi_x;
    logic [CW-1:0]          w_top;
    logic [CW-1:0]          k_m1;
    logic [CW:0]            pos_w;
    logic [CW:0]            pos_w_m1;
    logic                   err;
    logic                   take;
    logic [AW-1:0]          mem_addr;
    logic                   mem_we;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [CW-1:0]          found;

    // Live table size: zero acts as one, anything above the depth as the depth.
    always_comb begin
        size_x = CW'(r_size);
        if (r_size == '0) begin
            live_n = CW'(1);
        end else if (size_x > CW'(DEPTH)) begin
            live_n = CW'(DEPTH);
        end else begin
            live_n = size_x;
        end
    end

    assign lo_x = CW'(r_item.index_lo);
    assign hi_x = CW'(r_item.index_hi);

    // Index checks on the latched transaction.
    always_comb begin
        case (r_item.action)
            ACT_ADD, ACT_SET:     err = (lo_x >= live_n);
            ACT_SUM:              err = (lo_x > hi_x) || (hi_x > live_n);
            ACT_LOWER, ACT_UPPER: err = (lo_x > live_n);
            ACT_CLEAR:            err = 1'b0;
            default:              err = 1'b1;
        endcase
    end

    // Largest power of two not above the live size.
    always_comb begin
        w_top = '0;
        for (int b = 0; b < CW; b++) begin
            if (live_n[b]) begin
                w_top = CW'(1) << b;
            end
        end
    end

    assign k_m1     = r_k - 1'b1;
    assign pos_w    = {1'b0, r_pos} + {1'b0, r_w};
    assign pos_w_m1 = pos_w - 1'b1;

    // Search step test: keep the step when the cell stays below the target (lower) or does not exceed it (upper).
    always_comb begin
        if (r_item.action == ACT_UPPER) begin
            take = !($signed(r_target) < $signed(r_rdata));
        end else begin
            take = $signed(r_rdata) < $signed(r_target);
        end
    end

    // Memory address and write selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rdata + r_amt;
        if (i_cmd.upd_rd || i_cmd.upd_wr) begin
            mem_addr = r_ui[AW-1:0];
            mem_we   = i_cmd.upd_wr;
        end else if (i_cmd.srch_rd) begin
            mem_addr = pos_w_m1[AW-1:0];
        end else if (i_cmd.walk_rd) begin
            mem_addr = k_m1[AW-1:0];
        end else begin
            mem_addr  = r_ci;
            mem_we    = i_cmd.clr_wr;
            mem_wdata = '0;
        end
    end

    // Cell memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    // Clear sweep counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= '0;
        end else if (i_cmd.clr_init) begin
            r_ci <= '0;
        end else if (i_cmd.clr_wr) begin
            r_ci <= r_ci + 1'b1;
        end
    end

    // Transaction, prefix walk, update walk and search registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.walk1_init) begin
            r_acc <= '0;
            r_sub <= 1'b0;
            case (r_item.action)
                ACT_SUM: r_k <= hi_x;
                ACT_SET: r_k <= lo_x + 1'b1;
                default: r_k <= lo_x;
            endcase
        end else if (i_cmd.walk2_init) begin
            r_sub <= 1'b1;
            r_k   <= lo_x;
        end else if (i_cmd.walk_acc) begin
            r_acc <= r_sub ? (r_acc - r_rdata) : (r_acc + r_rdata);
            r_k   <= k_m1 & r_k;
        end
        if (i_cmd.upd_init) begin
            r_ui  <= lo_x;
            r_amt <= (r_item.action == ACT_SET) ? (r_item.value - r_acc) : r_item.value;
        end else if (i_cmd.upd_wr) begin
            r_ui <= r_ui | (r_ui + 1'b1);
        end
        if (i_cmd.srch_init) begin
            r_target <= r_item.value + r_acc;
            r_pos    <= '0;
            r_w      <= w_top;
        end else if (i_cmd.srch_cmp) begin
            if (take) begin
                r_target <= r_target - r_rdata;
                r_pos    <= pos_w[CW-1:0];
            end
            r_w <= r_w >> 1;
        end else if (i_cmd.srch_skip) begin
            r_w <= r_w >> 1;
        end
    end

    // Result assembly.
    always_comb begin
        if (err) begin
            found = live_n;
        end else if (r_pos < lo_x) begin
            found = lo_x;
        end else begin
            found = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_result.status      <= err;
            r_result.sum_value   <= (r_item.action == ACT_SUM && !err) ? r_acc : '0;
            r_result.found_index <= (r_item.action == ACT_LOWER ||
                                     r_item.action == ACT_UPPER) ? found[IDX_W-1:0] : '0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    assign o_stat.action   = r_item.action;
    assign o_stat.err      = err;
    assign o_stat.k_zero   = (r_k == '0);
    assign o_stat.upd_end  = (r_ui >= CW'(DEPTH));
    assign o_stat.w_zero   = (r_w == '0);
    assign o_stat.in_range = (pos_w <= {1'b0, live_n});
    assign o_stat.clr_last = (r_ci == AW'(DEPTH - 1));

endmodule

FILE: hw/rtl/fpst_ctrl.sv
// Controller state machine that sequences the table walks of each transaction.
module fpst_ctrl import fpst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT_CLR: if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:     if (i_start) n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else begin
                    case (i_stat.action)
                        ACT_ADD:                               n_state = S_URD;
                        ACT_SET, ACT_SUM, ACT_LOWER, ACT_UPPER: n_state = S_W1_RD;
                        ACT_CLEAR:                             n_state = S_CLR;
                        default:                               n_state = S_DONE;
                    endcase
                end
            end
            S_W1_RD: begin
                if (!i_stat.k_zero) begin
                    n_state = S_W1_ACC;
                end else if (i_stat.action == ACT_SET || i_stat.action == ACT_SUM) begin
                    n_state = S_W2_RD;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_W1_ACC: n_state = S_W1_RD;
            S_W2_RD: begin
                if (!i_stat.k_zero) begin
                    n_state = S_W2_ACC;
                end else if (i_stat.action == ACT_SET) begin
                    n_state = S_URD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_W2_ACC: n_state = S_W2_RD;
            S_URD:    n_state = i_stat.upd_end ? S_DONE : S_UWR;
            S_UWR:    n_state = S_URD;
            S_SRD: begin
                if (i_stat.w_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.in_range) begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP:   n_state = S_SRD;
            S_CLR:    if (i_stat.clr_last) n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_INIT_CLR: o_cmd.clr_wr = 1'b1;
            S_IDLE:     o_cmd.latch = i_start;
            S_DISPATCH: begin
                if (!i_stat.err) begin
                    case (i_stat.action)
                        ACT_ADD:                                o_cmd.upd_init = 1'b1;
                        ACT_SET, ACT_SUM, ACT_LOWER, ACT_UPPER: o_cmd.walk1_init = 1'b1;
                        ACT_CLEAR:                              o_cmd.clr_init = 1'b1;
                        default:                                o_cmd.done = 1'b0;
                    endcase
                end
            end
            S_W1_RD: begin
                if (!i_stat.k_zero) begin
                    o_cmd.walk_rd = 1'b1;
                end else if (i_stat.action == ACT_SET || i_stat.action == ACT_SUM) begin
                    o_cmd.walk2_init = 1'b1;
                end else begin
                    o_cmd.srch_init = 1'b1;
                end
            end
            S_W2_RD: begin
                if (!i_stat.k_zero) begin
                    o_cmd.walk_rd = 1'b1;
                end else if (i_stat.action == ACT_SET) begin
                    o_cmd.upd_init = 1'b1;
                end
            end
            S_W1_ACC, S_W2_ACC: o_cmd.walk_acc = 1'b1;
            S_URD:    o_cmd.upd_rd = !i_stat.upd_end;
            S_UWR:    o_cmd.upd_wr = 1'b1;
            S_SRD: begin
                if (!i_stat.w_zero) begin
                    o_cmd.srch_rd   = i_stat.in_range;
                    o_cmd.srch_skip = !i_stat.in_range;
                end
            end
            S_SCMP:   o_cmd.srch_cmp = 1'b1;
            S_CLR:    o_cmd.clr_wr = 1'b1;
            S_DONE:   o_cmd.done = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/fenwick_prefix_sum_table.sv
// Top level of the binary indexed prefix-sum table.
//
// A transaction is taken when start is high and busy is low; its one result
// appears on o_result for a single cycle with o_done, and must be captured
// then. All reads and writes of the cell memory go through one port, and each
// walk step reads a cell and then uses it: add takes one update walk, range
// sum and set take two prefix walks (set adds an update walk), searches take
// one prefix walk plus one step per bit of the size, and clear sweeps all
// DEPTH cells, one per cycle; a transaction that fails its index check or has
// an unused code goes to done without any walk. After reset the block clears
// all DEPTH cells of the memory and holds busy high meanwhile; the size
// register should be written only while no transaction is in flight.
module fenwick_prefix_sum_table import fpst_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_wdata,
    output logic             o_done,
    output t_out_item        o_result
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    fpst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Memory and arithmetic.
    fpst_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    // An accepted transaction keeps the block busy.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    // A result follows only a busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without work in progress");

    // Result strobes never come back to back.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

endmodule

FILE: tb/fpst_checker.sv
// Checker for the prefix-sum table: predicts each result and compares it.
`timescale 1ns / 1ps

module fpst_checker import fpst_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_wdata,
    input  logic             o_done,
    input  t_out_item        o_result,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    // Mirror of the tree cells and the size register.
    logic [VALUE_WIDTH-1:0] tree_mirror [DEPTH];
    logic [IDX_W-1:0]       size_mirror;
    t_out_item              due_results [$];

    function automatic int active_size();
        if (size_mirror == 0) return 1;
        if (size_mirror > DEPTH) return DEPTH;
        return int'(size_mirror);
    endfunction

    function automatic void tree_add(int slot, logic [VALUE_WIDTH-1:0] amount);
        for (int i = slot; i < DEPTH; i = i | (i + 1))
            tree_mirror[i] = tree_mirror[i] + amount;
    endfunction

    // Sum over slots [0, count).
    function automatic logic [VALUE_WIDTH-1:0] prefix_sum(int count);
        logic [VALUE_WIDTH-1:0] acc;
        int k;
        int i;
        acc = '0;
        k = (count > DEPTH) ? DEPTH : count;
        while (k > 0) begin
            i = k - 1;
            acc = acc + tree_mirror[i];
            k = i & (i + 1);
        end
        return acc;
    endfunction

    // Binary descent over the tree; strict looks for a sum exceeding the target.
    function automatic int bound_descent(logic [VALUE_WIDTH-1:0] target, bit strict, int n);
        int pos;
        int w;
        logic [VALUE_WIDTH-1:0] c;
        bit take;
        pos = 0;
        w = 1;
        while ((w << 1) <= n) w = w << 1;
        for (; w > 0; w = w >> 1) begin
            if (pos + w <= n) begin
                c = tree_mirror[pos + w - 1];
                take = strict ? !($signed(target) < $signed(c))
                              : ($signed(c) < $signed(target));
                if (take) begin
                    target = target - c;
                    pos = pos + w;
                end
            end
        end
        return pos;
    endfunction

    function automatic t_out_item predict_table_result(t_in_item it);
        t_out_item res;
        int n;
        int lo;
        int hi;
        int r;
        logic [VALUE_WIDTH-1:0] cur;
        res = '0;
        n = active_size();
        lo = int'(it.index_lo);
        hi = int'(it.index_hi);
        case (it.action)
            ACT_ADD, ACT_SET: begin
                if (lo >= n) begin
                    res.status = 1'b1;
                end else if (it.action == ACT_ADD) begin
                    tree_add(lo, it.value);
                end else begin
                    cur = prefix_sum(lo + 1) - prefix_sum(lo);
                    tree_add(lo, it.value - cur);
                end
            end
            ACT_SUM: begin
                if (lo > hi || hi > n) res.status = 1'b1;
                else res.sum_value = prefix_sum(hi) - prefix_sum(lo);
            end
            ACT_LOWER, ACT_UPPER: begin
                if (lo > n) begin
                    res.status = 1'b1;
                    res.found_index = IDX_W'(n);
                end else begin
                    r = bound_descent(it.value + prefix_sum(lo), it.action == ACT_UPPER, n);
                    res.found_index = IDX_W'((r < lo) ? lo : r);
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) tree_mirror[i] = '0;
            end
            default: res.status = 1'b1;
        endcase
        return res;
    endfunction

    // Compare finished results first, then track register writes and new transactions.
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) tree_mirror[i] = '0;
            size_mirror = SIZE_RESET;
            due_results.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            if (o_done) begin
                if (due_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected result %h at %0t", o_result, $realtime);
                end else begin
                    exp_res = due_results.pop_front();
                    o_checked++;
                    if (o_result !== exp_res) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("ERROR: result %0d sum %h/%h found %0d/%0d status %b/%b",
                                     o_checked, exp_res.sum_value, o_result.sum_value,
                                     exp_res.found_index, o_result.found_index,
                                     exp_res.status, o_result.status);
                    end
                end
            end
            if (i_cfg_we) size_mirror = i_cfg_wdata;
            if (start && !busy) due_results.push_back(predict_table_result(i_item));
        end
        o_pending = due_results.size();
    end

endmodule

FILE: tb/fenwick_prefix_sum_table_tb.sv
// Testbench top for the prefix-sum table: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module fenwick_prefix_sum_table_tb;
    import fpst_pkg::*;

    localparam logic [2:0] ACT_UNUSED_A = 3'd6;
    localparam logic [2:0] ACT_UNUSED_B = 3'd7;
    localparam int         IDLE_LIMIT   = 20000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in_item         i_item = '0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_wdata = '0;
    logic             o_done;
    t_out_item        o_result;
    int               fail_count;
    int               pending;
    int               checked;
    int               idle_cycles = 0;
    int               sent = 0;
    int               size_writes = 0;
    int               cur_size = 1024;

    fenwick_prefix_sum_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    fpst_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, sometimes long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Drive one transaction and hold it until the block takes it.
    task automatic issue(input logic [2:0] act, input int lo, input int hi,
                         input logic [31:0] val);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_item.action   = act;
        i_item.index_lo = IDX_W'(lo);
        i_item.index_hi = IDX_W'(hi);
        i_item.value    = val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    // Write the size register once all results are in.
    task automatic write_size(input int sz);
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = IDX_W'(sz);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        size_writes++;
        cur_size = (sz == 0) ? 1 : ((sz > 1024) ? 1024 : sz);
    endtask

    // Random transaction; positive phases keep contents positive for searches.
    task automatic random_item(input bit positive);
        int roll;
        int lo;
        int hi;
        logic [2:0] act;
        logic [31:0] val;
        roll = $urandom_range(0, 99);
        if (roll < 30) act = ACT_ADD;
        else if (roll < 45) act = ACT_SET;
        else if (roll < 65) act = ACT_SUM;
        else if (roll < 80) act = ACT_LOWER;
        else if (roll < 95) act = ACT_UPPER;
        else if (roll < 97 && !positive) act = ACT_CLEAR;
        else if (roll < 98) act = ($urandom_range(0, 1) != 0) ? ACT_UNUSED_A : ACT_UNUSED_B;
        else act = ACT_SUM;
        lo = $urandom_range(0, cur_size - 1);
        hi = $urandom_range(lo, cur_size);
        if ($urandom_range(0, 19) == 0) lo = $urandom_range(0, 2047);
        if ($urandom_range(0, 19) == 0) hi = $urandom_range(0, 2047);
        if (positive && (act == ACT_ADD || act == ACT_SET)) val = $urandom_range(1, 1000);
        else if (positive) val = $urandom_range(0, 20000);
        else val = $urandom;
        issue(act, lo, hi, val);
    endtask

    // One phase: a size setting followed by random traffic.
    task automatic run_phase(input int sz, input int count, input bit positive);
        write_size(sz);
        if (positive) begin
            issue(ACT_CLEAR, 0, 0, '0);
            for (int i = 0; i < cur_size && i < 64; i++)
                issue(ACT_ADD, i, 0, 32'($urandom_range(1, 500)));
        end
        repeat (count) random_item(positive);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, every action and the error cases.
        issue(ACT_ADD,     0,    0,    32'h7FFF_FFFF);
        issue(ACT_ADD,     1023, 0,    32'h8000_0000);
        issue(ACT_ADD,     1023, 0,    32'h8000_0000);
        issue(ACT_SET,     5,    0,    32'hFFFF_FFFF);
        issue(ACT_SUM,     0,    1024, '0);
        issue(ACT_SUM,     5,    6,    '0);
        issue(ACT_SUM,     7,    3,    '0);
        issue(ACT_SUM,     0,    1025, '0);
        issue(ACT_SUM,     2047, 2047, '0);
        issue(ACT_ADD,     1024, 0,    32'd1);
        issue(ACT_SET,     2047, 0,    32'd1);
        issue(ACT_LOWER,   0,    0,    32'h8000_0000);
        issue(ACT_UPPER,   1024, 0,    32'h7FFF_FFFF);
        issue(ACT_LOWER,   1025, 0,    '0);
        issue(ACT_UNUSED_A, 3,   4,    32'd9);
        issue(ACT_UNUSED_B, 2047, 2047, 32'hFFFF_FFFF);
        issue(ACT_CLEAR,   0,    0,    '0);
        issue(ACT_ADD,     2,    0,    32'd10);
        issue(ACT_ADD,     7,    0,    32'd5);
        issue(ACT_LOWER,   0,    0,    32'd10);
        issue(ACT_UPPER,   0,    0,    32'd10);
        issue(ACT_LOWER,   3,    0,    32'd6);
        issue(ACT_UPPER,   3,    0,    32'd100);

        // Random phases over several sizes, the extremes among them.
        run_phase(1,    40,  1'b0);
        run_phase(2,    40,  1'b1);
        run_phase(0,    20,  1'b0);
        run_phase(37,   90,  1'b1);
        run_phase(2047, 45,  1'b0);
        run_phase(1024, 75,  1'b1);
        run_phase(16,   70,  1'b1);
        run_phase($urandom_range(3, 1023), 75, 1'b0);

        // Drain and let the block settle.
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("Covered %0d transactions and %0d checked results over %0d size settings.",
                 sent, checked, size_writes);
        $display("Actions included add, set, range sum, both searches, clear and unused codes.");
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Mismatches: %0d, results still missing: %0d", fail_count, pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
